/* design/generational_handle_allocator_assert.svh */
// Assertion macros shared by the generational handle allocator RTL.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GHA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/gha_pkg.sv */
// Shared types and constants of the generational handle allocator.
`timescale 1ns / 1ps

package gha_pkg;

   // default sizing
   localparam int CAPACITY_DEFAULT = 1024;
   localparam int GEN_BITS_DEFAULT = 8;

   // request and response field widths
   localparam int CMD_W        = 2;
   localparam int INDEX_W      = 10;
   localparam int GEN_FIELD_W  = 8;
   localparam int STATUS_W     = 2;
   localparam int COUNT_W      = 11;
   localparam int REQ_TDATA_W  = 24;
   localparam int REQ_TUSER_W  = CMD_W;
   localparam int RSP_TDATA_W  = 32;

   typedef logic [INDEX_W-1:0]     index_type;
   typedef logic [GEN_FIELD_W-1:0] gen_field_type;
   typedef logic [COUNT_W-1:0]     count_field_type;

   // request commands
   typedef enum logic [CMD_W-1:0] {
      CMD_CREATE  = 2'd0,
      CMD_DESTROY = 2'd1,
      CMD_QUERY   = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE     = 2'd0,
      ST_NOT_LIVE = 2'd1,
      ST_FULL     = 2'd2
   } status_type;

endpackage

/* design/gha_ram.sv */
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module gha_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/generational_handle_allocator.sv */
// Generational handle allocator: top level with slot table and free queue.
//
// Usage:
//   Requests enter on the req_ channel (command in req_tuser, handle index and
//   generation in req_tdata). Each request yields exactly one response on the
//   rsp_ channel carrying status, the created handle, the liveness flag and
//   the live handle count after the request.
//   A request is taken while the slot table and the free queue are read;
//   once the read data is registered and the response register is free,
//   the read data is checked, the table and queue are written back and the
//   response register is loaded. A new request is taken only after that
//   write-back.
//   The response register lets a new request be taken while a response still
//   waits; if rsp_tready stays low, the next request holds in the write-back
//   stage and req_tready stays low until the response register frees up.
//   Reset empties the free queue and zeroes the handed-out and live counts;
//   the memories are not cleared, and a clear command does the same without
//   touching them. No clearing pass is needed.
`timescale 1ns / 1ps
`include "generational_handle_allocator_assert.svh"

module generational_handle_allocator #(
   parameter int CAPACITY = gha_pkg::CAPACITY_DEFAULT,
   parameter int GEN_BITS = gha_pkg::GEN_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [9:0] entity_index, [17:10] entity_generation, [23:18] zero
   input  logic [gha_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [gha_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [1:0] status, [11:2] new_index, [19:12] new_generation,
   // [20] is_alive, [31:21] alive_count
   output logic [gha_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > gha_pkg::INDEX_W) ? CNT_W : gha_pkg::INDEX_W;
   localparam int TBL_W  = GEN_BITS + 1;
   localparam int FIFO_W = GEN_BITS + IDX_W;

   typedef logic [IDX_W-1:0]    slot_type;
   typedef logic [CNT_W-1:0]    cnt_type;
   typedef logic [CMP_W-1:0]    cmp_type;
   typedef logic [GEN_BITS-1:0] gen_type;

   // next position in the circular free queue
   function automatic slot_type wrap_next(input slot_type pos);
      slot_type res;
      if (pos == slot_type'(CAPACITY - 1)) begin
         res = '0;
      end else begin
         res = pos + slot_type'(1);
      end
      return res;
   endfunction

   // control state
   logic    busy_ff, busy_in;
   slot_type free_head_ff, free_head_in;
   slot_type free_tail_ff, free_tail_in;
   cnt_type free_fill_ff, free_fill_in;
   cnt_type slots_used_ff, slots_used_in;
   cnt_type live_total_ff, live_total_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // payload state
   gha_pkg::cmd_type       cmd_ff;
   gha_pkg::index_type     idx_ff;
   gha_pkg::gen_field_type gen_ff;
   logic [gha_pkg::RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic             tbl_wr_en;
   slot_type         tbl_wr_addr;
   logic [TBL_W-1:0] tbl_wr_data;
   logic [TBL_W-1:0] tbl_rd_data;
   logic              fifo_wr_en;
   logic [FIFO_W-1:0] fifo_wr_data;
   logic [FIFO_W-1:0] fifo_rd_data;

   logic accept;
   logic exec_fire;
   logic handle_live;
   logic idx_in_range;
   gen_type  tbl_gen;
   gen_type  gen_bumped;
   slot_type slot_idx;
   slot_type fifo_slot;
   gen_type  fifo_gen;

   gha_pkg::status_type    rsp_status;
   gha_pkg::index_type     rsp_new_index;
   gha_pkg::gen_field_type rsp_new_gen;
   logic                   rsp_alive;

   // handshake
   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign exec_fire  = busy_ff && (!rsp_valid_ff || rsp_tready);

   // per-slot generation and live flag
   gha_ram #(
      .WIDTH (TBL_W),
      .DEPTH (CAPACITY)
   ) u_gen_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr_data),
      .rd_en   (accept),
      .rd_addr (slot_type'(req_tdata[gha_pkg::INDEX_W-1:0])),
      .rd_data (tbl_rd_data)
   );

   // queue of freed slots with their next generation
   gha_ram #(
      .WIDTH (FIFO_W),
      .DEPTH (CAPACITY)
   ) u_free_fifo (
      .clock   (clock),
      .wr_en   (fifo_wr_en),
      .wr_addr (free_tail_ff),
      .wr_data (fifo_wr_data),
      .rd_en   (accept),
      .rd_addr (free_head_ff),
      .rd_data (fifo_rd_data)
   );

   // liveness check on the read table entry
   assign tbl_gen      = tbl_rd_data[GEN_BITS-1:0];
   assign gen_bumped   = tbl_gen + gen_type'(1);
   assign slot_idx     = slot_type'(idx_ff);
   assign idx_in_range = cmp_type'(idx_ff) < cmp_type'(slots_used_ff);
   assign handle_live  = idx_in_range && tbl_rd_data[GEN_BITS] &&
                         (tbl_gen == gen_type'(gen_ff));
   assign fifo_slot    = fifo_rd_data[IDX_W-1:0];
   assign fifo_gen     = fifo_rd_data[FIFO_W-1:IDX_W];
   assign fifo_wr_data = {gen_bumped, slot_idx};

   // command execution and write-back
   always_comb begin
      busy_in       = busy_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      free_fill_in  = free_fill_ff;
      slots_used_in = slots_used_ff;
      live_total_in = live_total_ff;
      tbl_wr_en     = 1'b0;
      tbl_wr_addr   = slot_idx;
      tbl_wr_data   = {1'b0, gen_bumped};
      fifo_wr_en    = 1'b0;
      rsp_status    = gha_pkg::ST_DONE;
      rsp_new_index = '0;
      rsp_new_gen   = '0;
      rsp_alive     = 1'b0;

      if (exec_fire) begin
         unique case (cmd_ff)
            gha_pkg::CMD_CREATE: begin
               if (free_fill_ff != '0) begin
                  // reuse the oldest freed slot
                  free_head_in  = wrap_next(free_head_ff);
                  free_fill_in  = free_fill_ff - cnt_type'(1);
                  tbl_wr_en     = 1'b1;
                  tbl_wr_addr   = fifo_slot;
                  tbl_wr_data   = {1'b1, fifo_gen};
                  live_total_in = live_total_ff + cnt_type'(1);
                  rsp_new_index = gha_pkg::index_type'(fifo_slot);
                  rsp_new_gen   = gha_pkg::gen_field_type'(fifo_gen);
               end else if (slots_used_ff != cnt_type'(CAPACITY)) begin
                  // fresh slot, generation starts at zero
                  tbl_wr_en     = 1'b1;
                  tbl_wr_addr   = slot_type'(slots_used_ff);
                  tbl_wr_data   = {1'b1, gen_type'(0)};
                  slots_used_in = slots_used_ff + cnt_type'(1);
                  live_total_in = live_total_ff + cnt_type'(1);
                  rsp_new_index = gha_pkg::index_type'(slots_used_ff);
               end else begin
                  rsp_status = gha_pkg::ST_FULL;
               end
            end
            gha_pkg::CMD_DESTROY: begin
               if (handle_live) begin
                  tbl_wr_en     = 1'b1;
                  fifo_wr_en    = 1'b1;
                  free_tail_in  = wrap_next(free_tail_ff);
                  free_fill_in  = free_fill_ff + cnt_type'(1);
                  live_total_in = live_total_ff - cnt_type'(1);
                  rsp_alive     = 1'b1;
               end else begin
                  rsp_status = gha_pkg::ST_NOT_LIVE;
               end
            end
            gha_pkg::CMD_QUERY: begin
               rsp_alive = handle_live;
            end
            gha_pkg::CMD_CLEAR: begin
               free_head_in  = '0;
               free_tail_in  = '0;
               free_fill_in  = '0;
               slots_used_in = '0;
               live_total_in = '0;
            end
         endcase
      end

      // stage occupancy
      if (accept) begin
         busy_in = 1'b1;
      end else if (exec_fire) begin
         busy_in = 1'b0;
      end

      // response register
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {gha_pkg::count_field_type'(live_total_in), rsp_alive,
                         rsp_new_gen, rsp_new_index, rsp_status};
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
         rsp_data_in  = rsp_data_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         free_head_ff  <= '0;
         free_tail_ff  <= '0;
         free_fill_ff  <= '0;
         slots_used_ff <= '0;
         live_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         free_fill_ff  <= free_fill_in;
         slots_used_ff <= slots_used_in;
         live_total_ff <= live_total_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // request capture and response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= gha_pkg::cmd_type'(req_tuser);
         idx_ff <= req_tdata[gha_pkg::INDEX_W-1:0];
         gen_ff <= req_tdata[gha_pkg::INDEX_W +: gha_pkg::GEN_FIELD_W];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // every handed-out slot is either live or queued as free
   `GHA_ASSERT_SAME(a_slot_balance, clock, reset, 1'b1, (live_total_ff + free_fill_ff) == slots_used_ff, "slot accounting out of balance")
   // a successful destroy queues exactly one index
   `GHA_ASSERT_NEXT(a_destroy_queues, clock, reset, exec_fire && (cmd_ff == gha_pkg::CMD_DESTROY) && handle_live, free_fill_ff == ($past(free_fill_ff) + 1'b1), "destroy did not queue the slot")
   // a create served from the queue advances the queue head
   `GHA_ASSERT_NEXT(a_reuse_pops, clock, reset, exec_fire && (cmd_ff == gha_pkg::CMD_CREATE) && (free_fill_ff != '0), free_head_ff != $past(free_head_ff), "reused slot was not popped")

endmodule
